// ===== design/ttb_pkg.sv =====
package ttb_pkg;

   localparam int NUM_TIMERS = 8;
   localparam int IDX_W      = 3;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [KIND_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [KIND_W-1:0] REQ_START = 3'd1;
   localparam logic [KIND_W-1:0] REQ_CHECK = 3'd2;
   localparam logic [KIND_W-1:0] REQ_STOP  = 3'd3;
   localparam logic [KIND_W-1:0] REQ_READ  = 3'd4;

   typedef struct packed {
      logic             start_we;
      logic             dur_we;
      logic [IDX_W-1:0] addr;
   } ttb_wr_type;

endpackage

// ===== design/timeout_timer_bank.sv =====
// Bank of eight timeouts sharing one 32-bit wrapping time base. A word on
// req_ carries a request kind in tuser (tick, start, check, stop, read
// elapsed) and a timer index and duration in tdata; every word gives exactly
// one rsp_ word with timed_out, elapsed, was_running and the time base after
// the request. Start times and durations live in a synchronous memory with a
// registered read: the accept cycle issues the read, and the EXEC state
// computes, then writes back and loads the output register once that is free
// or draining. No new word is taken until the result is loaded; a stalled
// output holds the request in EXEC. Reset clears the time base and marks
// every timer stopped at start time zero.
module timeout_timer_bank (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // timer select, duration, zero pad
   input  logic [ttb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [ttb_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // timed_out, elapsed, was_running, time_report, zero pad
   output logic [ttb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ttb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [TIME_W-1:0]     dur_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  accept;
   logic                  fire;
   logic                  idx_ok;
   logic [TIME_W-1:0]     start_q;
   logic [TIME_W-1:0]     dur_q;
   logic [TIME_W-1:0]     el;
   logic                  running;
   logic                  timed_out;
   logic [TIME_W-1:0]     elapsed;
   ttb_wr_type            wr;
   logic [TIME_W-1:0]     dur_wdata;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   ttb_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_tdata[IDX_W-1:0]),
      .start_q (start_q),
      .dur_q   (dur_q),
      .wr      (wr),
      .start_d (time_ff),
      .dur_d   (dur_wdata)
   );

   assign idx_ok  = {1'b0, idx_ff} < (IDX_W + 1)'(NUM_TIMERS);
   assign el      = time_ff - start_q;
   assign running = idx_ok && (dur_q != '0);

   always_comb begin
      timed_out = 1'b0;
      elapsed   = '0;
      wr        = '{start_we: 1'b0, dur_we: 1'b0, addr: idx_ff};
      dur_wdata = dur_ff;
      if (idx_ok) begin
         case (kind_ff)
            REQ_START: begin
               wr.start_we = fire;
               wr.dur_we   = fire;
            end
            REQ_CHECK: begin
               elapsed   = el;
               timed_out = el > dur_q;
            end
            REQ_STOP: begin
               elapsed   = el;
               wr.dur_we = fire && running;
               dur_wdata = '0;
            end
            REQ_READ: begin
               elapsed = el;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      time_in  = time_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               if (req_tuser == REQ_TICK) begin
                  time_in = time_ff + 1'b1;
               end
            end
         end
         S_EXEC: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_tuser;
         idx_ff  <= req_tdata[IDX_W-1:0];
         dur_ff  <= req_tdata[IDX_W +: TIME_W];
      end
      if (fire) begin
         rsp_data_ff <= {(RSP_DATA_W - 2 * TIME_W - 2)'(0), time_ff, running,
                         elapsed, timed_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == REQ_TICK) |=> time_ff == $past(time_ff) + 1'b1)
      else $error("time base did not advance on tick");

   a_time_holds: assert property (@(posedge clock) disable iff (reset)
      !(accept && (req_tuser == REQ_TICK)) |=> $stable(time_ff))
      else $error("time base moved without tick");

   a_fire_loads: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid && (rsp_tdata[65:34] == $past(time_ff)))
      else $error("result word not loaded with time base");

   a_timeout_elapsed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] != '0)
      else $error("timeout reported with zero elapsed time");
`endif

endmodule

// ===== design/ttb_store.sv =====
module ttb_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [ttb_pkg::IDX_W-1:0]     rd_addr,
   output logic [ttb_pkg::TIME_W-1:0]    start_q,
   output logic [ttb_pkg::TIME_W-1:0]    dur_q,
   input  ttb_pkg::ttb_wr_type           wr,
   input  logic [ttb_pkg::TIME_W-1:0]    start_d,
   input  logic [ttb_pkg::TIME_W-1:0]    dur_d
);
   import ttb_pkg::*;

   logic [TIME_W-1:0]     start_mem [NUM_TIMERS];
   logic [TIME_W-1:0]     dur_mem   [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] vld_ff;
   logic [NUM_TIMERS-1:0] vld_in;
   logic [TIME_W-1:0]     start_rd_ff;
   logic [TIME_W-1:0]     dur_rd_ff;
   logic                  vld_rd_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.start_we) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.start_we) begin
         start_mem[wr.addr] <= start_d;
      end
      if (wr.dur_we) begin
         dur_mem[wr.addr] <= dur_d;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         start_rd_ff <= start_mem[rd_addr];
         dur_rd_ff   <= dur_mem[rd_addr];
         vld_rd_ff   <= vld_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   assign start_q = vld_rd_ff ? start_rd_ff : '0;
   assign dur_q   = vld_rd_ff ? dur_rd_ff : '0;

endmodule

// ===== sim/timeout_timer_bank_tb.sv =====
module timeout_timer_bank_tb;
   import ttb_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 6;
   localparam int PHASE_WORDS   = 200;

   localparam logic [KIND_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] REQ_SPARE_MID   = 3'd6;
   localparam logic [KIND_W-1:0] REQ_SPARE_LAST  = 3'd7;

   typedef struct {
      logic              timed_out;
      logic [TIME_W-1:0] elapsed;
      logic              was_running;
      logic [TIME_W-1:0] time_report;
   } timer_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = REQ_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted timer state
   logic [TIME_W-1:0] time_base;
   logic [TIME_W-1:0] start_at [NUM_TIMERS];
   logic [TIME_W-1:0] limit_of [NUM_TIMERS];

   timer_result_type pending_results[$];

   int  sender_idle_pct = 0;
   int  rsp_stall_pct = 0;
   logic hold_req = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  mismatches = 0;
   int  words_sent = 0;
   int  results_checked = 0;
   int  expiries_seen = 0;

   timeout_timer_bank i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic void clear_timer_model();
      time_base = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         start_at[i] = '0;
         limit_of[i] = '0;
      end
   endfunction

   function automatic void predict_timer_request(logic [KIND_W-1:0] kind,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [TIME_W-1:0] dur);
      timer_result_type  res;
      logic [TIME_W-1:0] since_start;
      if (kind == REQ_TICK) begin
         time_base = time_base + 1'b1;
      end
      res.timed_out   = 1'b0;
      res.elapsed     = '0;
      res.was_running = 1'b0;
      if (idx < NUM_TIMERS) begin
         since_start     = time_base - start_at[idx];
         res.was_running = (limit_of[idx] != '0);
         case (kind)
            REQ_START: begin
               start_at[idx] = time_base;
               limit_of[idx] = dur;
            end
            REQ_CHECK: begin
               res.elapsed   = since_start;
               res.timed_out = (since_start > limit_of[idx]);
            end
            REQ_STOP: begin
               res.elapsed = since_start;
               if (res.was_running) begin
                  limit_of[idx] = '0;
               end
            end
            REQ_READ: begin
               res.elapsed = since_start;
            end
            default: ;
         endcase
      end
      res.time_report = time_base;
      pending_results.push_back(res);
   endfunction

   task automatic send_req(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [TIME_W-1:0] dur);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-IDX_W-TIME_W){1'b0}}, dur, idx};
      do @(posedge clock); while (!req_tready);
      predict_timer_request(kind, idx, dur);
      words_sent++;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void compare_field(string field, logic [TIME_W-1:0] want,
                                         logic [TIME_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("timed_out", TIME_W'(want.timed_out), TIME_W'(rsp_tdata[0]));
            compare_field("elapsed", want.elapsed, rsp_tdata[32:1]);
            compare_field("was_running", TIME_W'(want.was_running), TIME_W'(rsp_tdata[33]));
            compare_field("time_report", want.time_report, rsp_tdata[65:34]);
            results_checked++;
            if (rsp_tdata[0]) begin
               expiries_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      send_req(REQ_CHECK, 3'd0, '0);
      send_req(REQ_READ, 3'd3, '0);
      send_req(REQ_STOP, 3'd2, '0);
      send_req(REQ_SPARE_FIRST, 3'd4, '0);
      send_req(REQ_TICK, 3'd0, '0);
      send_req(REQ_CHECK, 3'd0, '0);
      send_req(REQ_START, 3'd1, 32'd3);
      send_req(REQ_START, 3'd7, '1);
      send_req(REQ_START, 3'd5, '0);
      repeat (3) send_req(REQ_TICK, 3'd2, '0);
      send_req(REQ_CHECK, 3'd1, '0);
      send_req(REQ_CHECK, 3'd5, '0);
      send_req(REQ_TICK, 3'd6, '0);
      send_req(REQ_CHECK, 3'd1, '0);
      send_req(REQ_CHECK, 3'd7, '0);
      send_req(REQ_STOP, 3'd1, '0);
      send_req(REQ_STOP, 3'd1, '0);
      send_req(REQ_READ, 3'd7, '0);
      send_req(REQ_SPARE_MID, 3'd7, '0);
      send_req(REQ_SPARE_LAST, 3'd1, '1);
      send_req(REQ_START, 3'd6, 32'h0000ffff);
      send_req(REQ_TICK, 3'd7, '1);
      send_req(REQ_CHECK, 3'd6, '1);
   endtask

   task automatic test_random(int words, int idle_pct, int stall_pct);
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] dur;
      int                pick;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      repeat (words) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            kind = REQ_TICK;
         end else if (pick < 50) begin
            kind = REQ_START;
         end else if (pick < 70) begin
            kind = REQ_CHECK;
         end else if (pick < 80) begin
            kind = REQ_STOP;
         end else if (pick < 92) begin
            kind = REQ_READ;
         end else begin
            kind = KIND_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
         end
         pick = $urandom_range(9);
         if (kind != REQ_START) begin
            dur = $urandom();
         end else if (pick == 0) begin
            dur = '0;
         end else if (pick < 7) begin
            dur = $urandom_range(1, 24);
         end else if (pick < 8) begin
            dur = $urandom_range(25, 400);
         end else begin
            dur = $urandom();
         end
         send_req(kind, IDX_W'($urandom_range(NUM_TIMERS-1)), dur);
      end
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      for (int i = 0; i < 24; i++) begin
         send_req(i % 3 == 0 ? REQ_TICK : REQ_CHECK, IDX_W'(i), $urandom());
      end
   endtask

   initial begin
      clear_timer_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(PHASE_WORDS, 0, 0);
      test_random(PHASE_WORDS, 78, 0);
      test_backpressure();
      test_random(PHASE_WORDS, 0, 78);
      test_random(PHASE_WORDS, 7, 7);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d request words over four stall mixes and one long hold-off",
               words_sent);
      $display("checked %0d result words, %0d of them reporting a timeout",
               results_checked, expiries_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
